/* sv/zcs_pkg.sv */
// Shared constants, types and state codes for the zero compaction block.
package zcs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int DATA_BITS = ((WORD_BITS + 7) / 8) * 8;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;
    typedef logic [CNT_BITS-1:0]         cnt_t;

    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } mem_req_t;

    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_RD_I     = 7'b0000010,
        S_CHK_I    = 7'b0000100,
        S_CHK_T    = 7'b0001000,
        S_SWAP     = 7'b0010000,
        S_EMIT_RD  = 7'b0100000,
        S_EMIT_OUT = 7'b1000000
    } state_t;

endpackage

/* sv/zcs_mem.sv */
// List store: one write port and one read port with registered read data.
module zcs_mem
    import zcs_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output word_t    rd_data
);

    word_t mem [MAX_ITEMS];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/zcs_ctrl.sv */
// Sequencer: loads the list, runs the two-pointer walk and emits the result.
module zcs_ctrl
    import zcs_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  word_t          s_word,
    input  logic           s_final,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           m_last,
    output logic           m_ovf,
    output mem_req_t       req,
    input  word_t          rd_data
);

    state_t state_reg, state_next;
    cnt_t   fill_reg, fill_next;
    cnt_t   i_reg, i_next;
    cnt_t   tail_reg, tail_next;
    logic   ovf_reg, ovf_next;
    cnt_t   i_plus1;
    cnt_t   tail_dec;
    logic   rd_zero;

    assign i_plus1  = i_reg + cnt_t'(1);
    assign tail_dec = tail_reg - cnt_t'(1);
    assign rd_zero  = (rd_data == '0);

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_EMIT_OUT);
    assign m_last   = (i_plus1 == fill_reg);
    assign m_ovf    = ovf_reg;

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        i_next      = i_reg;
        tail_next   = tail_reg;
        ovf_next    = ovf_reg;
        req.wr_en   = 1'b0;
        req.wr_addr = fill_reg[ADDR_BITS-1:0];
        req.wr_data = s_word;
        req.rd_en   = 1'b0;
        req.rd_addr = i_reg[ADDR_BITS-1:0];
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (fill_reg < cnt_t'(MAX_ITEMS)) begin
                        req.wr_en = 1'b1;
                        fill_next = fill_reg + cnt_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_final) begin
                        i_next    = '0;
                        tail_next = fill_next;
                        state_next = (fill_next <= cnt_t'(1)) ? S_EMIT_RD : S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                if (i_plus1 < tail_reg) begin
                    req.rd_en  = 1'b1;
                    state_next = S_CHK_I;
                end else begin
                    i_next     = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_CHK_I: begin
                if (rd_zero) begin
                    tail_next   = tail_dec;
                    req.rd_en   = 1'b1;
                    req.rd_addr = tail_dec[ADDR_BITS-1:0];
                    state_next  = S_CHK_T;
                end else begin
                    i_next     = i_plus1;
                    state_next = S_RD_I;
                end
            end
            S_CHK_T: begin
                if ((tail_reg > i_plus1) && rd_zero) begin
                    tail_next   = tail_dec;
                    req.rd_en   = 1'b1;
                    req.rd_addr = tail_dec[ADDR_BITS-1:0];
                end else begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = i_reg[ADDR_BITS-1:0];
                    req.wr_data = rd_data;
                    state_next  = S_SWAP;
                end
            end
            S_SWAP: begin
                req.wr_en   = 1'b1;
                req.wr_addr = tail_reg[ADDR_BITS-1:0];
                req.wr_data = '0;
                i_next      = i_plus1;
                state_next  = S_RD_I;
            end
            S_EMIT_RD: begin
                req.rd_en  = 1'b1;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (m_tready) begin
                    if (m_last) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        i_next     = '0;
                        state_next = S_LOAD;
                    end else begin
                        i_next     = i_plus1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            tail_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

/* sv/zero_compaction_two_pointer_swap_top.sv */
// Top level of the zero compaction block: list store and sequencer.
//
// Usage: send the list on the s_ channel, one word per cycle, with s_tlast
// on the closing word. Words beyond MAX_ITEMS are dropped and the whole
// list is flagged on m_tuser. After the closing word the list is compacted
// in place: zeros are swapped with the last nonzero words, order is not kept.
// The compacted list leaves on the m_ channel in index order, m_tlast on the
// final word.
// Walk: each index is read and checked; for each zero, trailing zeros are
// skipped from the tail, then the word found there is written to the zero's
// index and a zero to the tail; all reads share the single read port of the
// list store. Emission reads each word, then presents it.
// s_tready is low from the closing word until the last result word is taken.
// Stall: m_tdata holds in the read register while m_tready is low.
// Reset: aresetn, synchronous and active low, empties the list and clears
// the overflow flag; the store contents are not cleared.
module zero_compaction_two_pointer_swap_top
    import zcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // [WORD_BITS-1:0] word
    input  logic                 s_tlast,   // final_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,   // [WORD_BITS-1:0] result_word
    output logic                 m_tlast,   // result_last
    output logic                 m_tuser    // overflow
);

    mem_req_t req;
    word_t    rd_data;

    zcs_mem u_mem (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    zcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (s_tdata[WORD_BITS-1:0]),
        .s_final  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_last   (m_tlast),
        .m_ovf    (m_tuser),
        .req      (req),
        .rd_data  (rd_data)
    );

    assign m_tdata = DATA_BITS'({1'b0, rd_data});

endmodule

/* dv/tb.sv */
// Self-checking bench for the zero compaction block: directed and random lists in, compacted words checked.
`timescale 1ns / 100ps

module tb;
    import zcs_pkg::*;

    typedef struct {
        word_t word;
        logic  last;
    } list_word_t;

    typedef struct {
        word_t word;
        logic  last;
        logic  ovf;
    } packed_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata  = '0;   // [WORD_BITS-1:0] word
    logic                 s_tlast  = 1'b0; // final_req
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;         // [WORD_BITS-1:0] result_word
    logic                 m_tlast;         // result_last
    logic                 m_tuser;         // overflow

    list_word_t     pending_words[$];
    packed_result_t compacted_out[$];
    list_word_t     on_bus;

    word_t shadow_list[MAX_ITEMS];
    int    shadow_fill = 0;
    logic  shadow_drop = 1'b0;

    int   total_words    = 0;
    int   words_accepted = 0;
    int   mismatches     = 0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   quiet_left     = 0;
    logic quiet          = 1'b0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    logic hold_used      = 1'b0;

    zero_compaction_two_pointer_swap_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [DATA_BITS-1:0] pad_word(word_t w);
        logic [DATA_BITS-1:0] d;
        d = '0;
        d[WORD_BITS-1:0] = w;
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t rand_word(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        case ($urandom_range(0, 9))
            0: return {1'b1, {(WORD_BITS-1){1'b0}}};
            1: return {1'b0, {(WORD_BITS-1){1'b1}}};
            2: return '1;
            3: return word_t'(1);
            default: return word_t'($urandom);
        endcase
    endfunction

    // Store, then on the closing word compact and queue the whole list.
    function automatic void predict_word(list_word_t lw);
        int             tail;
        word_t          tmp;
        packed_result_t r;
        if (shadow_fill < MAX_ITEMS) begin
            shadow_list[shadow_fill] = lw.word;
            shadow_fill++;
        end else begin
            shadow_drop = 1'b1;
        end
        if (!lw.last) return;
        if (shadow_fill > 1) begin
            tail = shadow_fill;
            for (int i = 0; i + 1 < tail; i++) begin
                if (shadow_list[i] == '0) begin
                    do begin
                        tail--;
                    end while (tail > i + 1 && shadow_list[tail] == '0);
                    if (tail > i) begin
                        tmp               = shadow_list[i];
                        shadow_list[i]    = shadow_list[tail];
                        shadow_list[tail] = tmp;
                    end
                end
            end
        end
        for (int k = 0; k < shadow_fill; k++) begin
            r.word = shadow_list[k];
            r.last = (k + 1 == shadow_fill);
            r.ovf  = shadow_drop;
            compacted_out.push_back(r);
        end
        shadow_fill = 0;
        shadow_drop = 1'b0;
    endfunction

    task automatic send_list(input word_t ws[$]);
        list_word_t lw;
        foreach (ws[k]) begin
            lw.word = ws[k];
            lw.last = (k == ws.size() - 1);
            pending_words.push_back(lw);
            total_words++;
        end
    endtask

    task automatic random_list(int n, int zero_pct);
        word_t ws[$];
        for (int k = 0; k < n; k++) ws.push_back(rand_word(zero_pct));
        send_list(ws);
    endtask

    always @(posedge aclk) begin
        if (quiet_left == 0) begin
            quiet <= ~quiet;
            quiet_left = $urandom_range(50, 300);
        end else begin
            quiet_left--;
        end
    end

    // Hold off the receiver once, mid-list, long enough to back up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count <= 0;
            hold_left   <= 0;
            hold_used   <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (!hold_used && cycle_count >= 600 && m_tvalid) begin
                hold_left <= 400;
                hold_used <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(on_bus);
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    on_bus = pending_words.pop_front();
                    s_tdata  <= pad_word(on_bus.word);
                    s_tlast  <= on_bus.last;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        packed_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (compacted_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: data %h last %b ovf %b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    exp_r = compacted_out.pop_front();
                    if (m_tdata !== pad_word(exp_r.word) || m_tlast !== exp_r.last ||
                        m_tuser !== exp_r.ovf) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     pad_word(exp_r.word), exp_r.last, exp_r.ovf,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial begin : stimulus
        word_t dl[$];
        logic  big_done;
        logic  over_done;
        big_done  = 1'b0;
        over_done = 1'b0;

        dl = '{word_t'(5)};
        send_list(dl);
        dl = '{word_t'(0)};
        send_list(dl);
        dl = '{word_t'(0), word_t'(0)};
        send_list(dl);
        dl = '{{1'b1, {(WORD_BITS-1){1'b0}}}, word_t'(0)};
        send_list(dl);
        dl = '{word_t'(0), {1'b0, {(WORD_BITS-1){1'b1}}}};
        send_list(dl);
        dl = '{word_t'(0), word_t'(-1), word_t'(0), word_t'(1), word_t'(0)};
        send_list(dl);
        dl = '{word_t'(0), word_t'(0), word_t'(0), word_t'(7)};
        send_list(dl);
        dl = '{word_t'(-1), word_t'(2), word_t'(3)};
        send_list(dl);
        dl = '{word_t'(0), word_t'(9), word_t'(0), word_t'(0), word_t'(8)};
        send_list(dl);

        while (total_words < 200) begin
            if (!big_done && total_words > 60) begin
                random_list(MAX_ITEMS, $urandom_range(0, 60));
                big_done = 1'b1;
            end else if (!over_done && total_words > 130) begin
                random_list(MAX_ITEMS + 1, $urandom_range(0, 60));
                over_done = 1'b1;
            end else begin
                random_list(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                        : $urandom_range(1, 8),
                            $urandom_range(0, 100));
            end
        end
        random_list(MAX_ITEMS + 3, $urandom_range(0, 100));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_accepted < total_words) @(negedge aclk);
        while (compacted_out.size() > 0) @(negedge aclk);
        repeat (300) @(negedge aclk);

        if (mismatches == 0) begin
            $display("[zero_compaction_two_pointer_swap_top] OK");
        end else begin
            $display("[zero_compaction_two_pointer_swap_top] ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[zero_compaction_two_pointer_swap_top] ERROR");
        $finish;
    end

endmodule
